// ===== rtl/frs_pkg.sv =====
// Shared types and constants for the flush relay sequencer.
`timescale 1ns / 1ps

package frs_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;

   localparam logic [TIME_W-1:0] PRIME_MS_RST  = 32'd120000;
   localparam logic [TIME_W-1:0] TOGGLE_MS_RST = 32'd60000;
   localparam logic [TIME_W-1:0] FINISH_MS_RST = 32'd180000;
   localparam logic [TIME_W-1:0] TOTAL_MS_RST  = 32'd10800000;

   typedef enum logic [1:0] {
      REG_PRIME  = 2'd0,
      REG_TOGGLE = 2'd1,
      REG_FINISH = 2'd2,
      REG_TOTAL  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] prime_ms;
      logic [TIME_W-1:0] toggle_ms;
      logic [TIME_W-1:0] finish_ms;
      logic [TIME_W-1:0] total_ms;
   } cfg_type;

endpackage

// ===== rtl/frs_csr.sv =====
// APB register file holding the sequence timing settings.
`timescale 1ns / 1ps

module frs_csr
   import frs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_PRIME:  cfg_in.prime_ms  = csr_pwdata;
            REG_TOGGLE: cfg_in.toggle_ms = csr_pwdata;
            REG_FINISH: cfg_in.finish_ms = csr_pwdata;
            REG_TOTAL:  cfg_in.total_ms  = csr_pwdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_PRIME:  csr_prdata = cfg_ff.prime_ms;
         REG_TOGGLE: csr_prdata = cfg_ff.toggle_ms;
         REG_FINISH: csr_prdata = cfg_ff.finish_ms;
         REG_TOTAL:  csr_prdata = cfg_ff.total_ms;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prime_ms  <= PRIME_MS_RST;
         cfg_ff.toggle_ms <= TOGGLE_MS_RST;
         cfg_ff.finish_ms <= FINISH_MS_RST;
         cfg_ff.total_ms  <= TOTAL_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/frs_core.sv =====
// Poll register, sequencer state update and result register.
`timescale 1ns / 1ps

module frs_core
   import frs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_switch_on,
   input  logic              req_switch_flush,
   input  logic [TIME_W-1:0] req_now_ms,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_inlet_relay,
   output logic              rsp_outlet_relay
);

   // poll register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_on_ff, s1_flush_ff;
   logic [TIME_W-1:0] s1_now_ff;

   // sequencer state
   logic              want_inlet_ff, want_inlet_in;
   logic              want_outlet_ff, want_outlet_in;
   logic              pin_inlet_ff, pin_inlet_in;
   logic              pin_outlet_ff, pin_outlet_in;
   logic              running_ff, running_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] last_ff, last_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              out_inlet_ff, out_outlet_ff;

   logic              out_free;
   logic              advance;
   logic              req_take;
   logic              run_pos, flush_pos;
   logic [TIME_W-1:0] start_eff, last_eff;
   logic [TIME_W-1:0] done, since_last, since_start;
   logic              prime_hit, toggle_hit, finish_hit, restamp;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign run_pos   = s1_on_ff && !s1_flush_ff;
   assign flush_pos = s1_flush_ff && !s1_on_ff;

   assign start_eff   = running_ff ? start_ff : s1_now_ff;
   assign last_eff    = running_ff ? last_ff : s1_now_ff;
   assign done        = last_eff - start_eff;
   assign since_last  = s1_now_ff - last_eff;
   assign since_start = s1_now_ff - start_eff;

   assign prime_hit  = done <= cfg.prime_ms;
   assign toggle_hit = !prime_hit && (done <= cfg.total_ms) && (since_last >= cfg.toggle_ms);
   assign restamp    = prime_hit || toggle_hit;
   // after a restamp the time since the last event is zero
   assign finish_hit = restamp || (since_last <= cfg.finish_ms);

   always_comb begin
      want_inlet_in  = want_inlet_ff;
      want_outlet_in = want_outlet_ff;
      pin_inlet_in   = pin_inlet_ff;
      pin_outlet_in  = pin_outlet_ff;
      running_in     = running_ff;
      start_in       = start_ff;
      last_in        = last_ff;
      if (advance) begin
         if (run_pos) begin
            want_inlet_in  = 1'b1;
            want_outlet_in = 1'b0;
            pin_inlet_in   = 1'b1;
            pin_outlet_in  = 1'b0;
            running_in     = 1'b0;
         end else if (flush_pos) begin
            running_in = 1'b1;
            start_in   = start_eff;
            last_in    = restamp ? s1_now_ff : last_eff;
            if (prime_hit) begin
               want_inlet_in  = 1'b1;
               want_outlet_in = 1'b0;
               pin_inlet_in   = 1'b1;
               pin_outlet_in  = 1'b0;
            end else if (toggle_hit) begin
               want_inlet_in  = !want_inlet_ff;
               want_outlet_in = !want_outlet_ff;
               pin_inlet_in   = !want_inlet_ff;
               pin_outlet_in  = !want_outlet_ff;
            end
            if (since_start >= cfg.total_ms) begin
               pin_inlet_in  = finish_hit;
               pin_outlet_in = 1'b0;
            end
         end else begin
            pin_inlet_in  = 1'b0;
            pin_outlet_in = 1'b0;
            running_in    = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !advance);
      if (advance) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         want_inlet_ff  <= 1'b0;
         want_outlet_ff <= 1'b0;
         pin_inlet_ff   <= 1'b0;
         pin_outlet_ff  <= 1'b0;
         running_ff     <= 1'b0;
         start_ff       <= '0;
         last_ff        <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
         want_inlet_ff  <= want_inlet_in;
         want_outlet_ff <= want_outlet_in;
         pin_inlet_ff   <= pin_inlet_in;
         pin_outlet_ff  <= pin_outlet_in;
         running_ff     <= running_in;
         start_ff       <= start_in;
         last_ff        <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_on_ff    <= req_switch_on;
         s1_flush_ff <= req_switch_flush;
         s1_now_ff   <= req_now_ms;
      end
      if (advance) begin
         out_inlet_ff  <= pin_inlet_in;
         out_outlet_ff <= pin_outlet_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_inlet_relay  = out_inlet_ff;
   assign rsp_outlet_relay = out_outlet_ff;

endmodule

// ===== rtl/flush_relay_sequencer.sv =====
// Flush relay sequencer top level.
`timescale 1ns / 1ps

// Each poll item (run and flush switch levels plus a millisecond time) yields
// one item with the latched inlet and outlet relay drives. A poll is captured
// in an input register; when the output register is free, the sequencer state
// and relay drives are updated and written to that output register, and one
// poll is taken every cycle while the result side keeps up.
// Run position drives the inlet only; flush position runs prime, alternation
// and finish phases timed from the poll on which flush was entered; any other
// switch combination turns both relays off. All time differences wrap modulo
// 2^32. Timing settings live in four 32-bit registers at byte addresses 0x0
// (prime), 0x4 (toggle), 0x8 (finish) and 0xC (total); they are to be written
// only while no poll is in flight, which the block itself does not enforce.

module flush_relay_sequencer
   import frs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_switch_on,
   input  logic              req_switch_flush,
   input  logic [TIME_W-1:0] req_now_ms,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_inlet_relay,
   output logic              rsp_outlet_relay
);

   cfg_type cfg;

   frs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   frs_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_switch_on    (req_switch_on),
      .req_switch_flush (req_switch_flush),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inlet_relay  (rsp_inlet_relay),
      .rsp_outlet_relay (rsp_outlet_relay)
   );

endmodule

// ===== rtl/frs_checker.sv =====
// Port-level checks for the flush relay sequencer, bound to the top level.
`timescale 1ns / 1ps

module frs_checker (
   input logic clock,
   input logic reset,
   input logic csr_pready,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_inlet_relay,
   input logic rsp_outlet_relay
);

   // relays are never both driven
   a_no_double_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_inlet_relay && rsp_outlet_relay))
      else $error("inlet and outlet driven together");

   // an empty output register means the poll register drains
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("poll stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inlet_relay)
                                 && $stable(rsp_outlet_relay))
      else $error("stalled item changed");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind flush_relay_sequencer frs_checker u_frs_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_pready       (csr_pready),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_inlet_relay  (rsp_inlet_relay),
   .rsp_outlet_relay (rsp_outlet_relay)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the flush relay sequencer: random polls against a relay predictor.
`timescale 1ns / 1ps

module tb_top;
   import frs_pkg::*;

   typedef struct packed {
      logic              sw_on;
      logic              sw_flush;
      logic [TIME_W-1:0] now_ms;
   } poll_type;

   typedef struct packed {
      logic inlet;
      logic outlet;
   } relay_pair_type;

   typedef struct packed {
      logic              want_inlet;
      logic              want_outlet;
      logic              pin_inlet;
      logic              pin_outlet;
      logic              running;
      logic [TIME_W-1:0] start_stamp;
      logic [TIME_W-1:0] last_stamp;
   } flush_state_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT
   } stall_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_switch_on = 1'b0;
   logic              req_switch_flush = 1'b0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_inlet_relay;
   logic              rsp_outlet_relay;

   poll_type        pending_polls[$];
   relay_pair_type  relay_expect_q[$];
   cfg_type         timing;
   flush_state_type flush_seq;
   int              fail_count = 0;
   int              polls_queued = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              stall_span = 0;
   int              stall_tick = 0;
   stall_mode_type  stall_mode = STALL_NONE;

   flush_relay_sequencer dut (.*);

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic relay_pair_type predict_relays(input logic sw_on, input logic sw_flush,
                                                     input logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0] done_ms;
      logic [TIME_W-1:0] since_last;
      logic [TIME_W-1:0] since_start;
      relay_pair_type    r;
      if (sw_on && !sw_flush) begin
         flush_seq.want_inlet  = 1'b1;
         flush_seq.want_outlet = 1'b0;
         flush_seq.pin_inlet   = 1'b1;
         flush_seq.pin_outlet  = 1'b0;
         flush_seq.running     = 1'b0;
      end else if (sw_flush && !sw_on) begin
         if (!flush_seq.running) begin
            flush_seq.start_stamp = now_ms;
            flush_seq.last_stamp  = now_ms;
            flush_seq.running     = 1'b1;
         end
         done_ms    = flush_seq.last_stamp - flush_seq.start_stamp;
         since_last = now_ms - flush_seq.last_stamp;
         if (done_ms <= timing.prime_ms) begin
            flush_seq.want_inlet  = 1'b1;
            flush_seq.want_outlet = 1'b0;
            flush_seq.pin_inlet   = 1'b1;
            flush_seq.pin_outlet  = 1'b0;
            flush_seq.last_stamp  = now_ms;
         end else if (done_ms <= timing.total_ms && since_last >= timing.toggle_ms) begin
            flush_seq.want_inlet  = ~flush_seq.want_inlet;
            flush_seq.want_outlet = ~flush_seq.want_outlet;
            flush_seq.pin_inlet   = flush_seq.want_inlet;
            flush_seq.pin_outlet  = flush_seq.want_outlet;
            flush_seq.last_stamp  = now_ms;
         end
         since_start = now_ms - flush_seq.start_stamp;
         since_last  = now_ms - flush_seq.last_stamp;
         if (since_start >= timing.total_ms) begin
            flush_seq.pin_inlet  = (since_last <= timing.finish_ms);
            flush_seq.pin_outlet = 1'b0;
         end
      end else begin
         flush_seq.pin_inlet  = 1'b0;
         flush_seq.pin_outlet = 1'b0;
         flush_seq.running    = 1'b0;
      end
      r.inlet  = flush_seq.pin_inlet;
      r.outlet = flush_seq.pin_outlet;
      return r;
   endfunction

   // poll driver: bursts of random length, random gaps
   always @(posedge clock) begin
      poll_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            relay_expect_q.push_back(predict_relays(req_switch_on, req_switch_flush, req_now_ms));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_polls.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               nxt = pending_polls.pop_front();
               req_valid        <= 1'b1;
               req_switch_on    <= nxt.sw_on;
               req_switch_flush <= nxt.sw_flush;
               req_now_ms       <= nxt.now_ms;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // result side stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 200);
         end else begin
            stall_span--;
         end
         stall_tick++;
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_COIN: rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= (stall_tick % 3 != 0);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      relay_pair_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (relay_expect_q.size() == 0) begin
            $error("unexpected item: inlet %0b outlet %0b", rsp_inlet_relay, rsp_outlet_relay);
            fail_count++;
         end else begin
            due = relay_expect_q.pop_front();
            if (rsp_inlet_relay !== due.inlet) begin
               $error("inlet_relay: expected %0b, got %0b", due.inlet, rsp_inlet_relay);
               fail_count++;
            end
            if (rsp_outlet_relay !== due.outlet) begin
               $error("outlet_relay: expected %0b, got %0b", due.outlet, rsp_outlet_relay);
               fail_count++;
            end
         end
      end
   end

   task automatic add_poll(input logic sw_on, input logic sw_flush, input logic [TIME_W-1:0] t);
      poll_type p;
      p.sw_on    = sw_on;
      p.sw_flush = sw_flush;
      p.now_ms   = t;
      pending_polls.push_back(p);
      polls_queued++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_polls.size() != 0 || req_valid || relay_expect_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [DATA_W-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PRIME:  timing.prime_ms  = val;
         REG_TOGGLE: timing.toggle_ms = val;
         REG_FINISH: timing.finish_ms = val;
         default:    timing.total_ms  = val;
      endcase
   endtask

   task automatic set_timing(input logic [31:0] prime, input logic [31:0] toggle,
                             input logic [31:0] finish, input logic [31:0] total);
      write_reg(REG_PRIME, prime);
      write_reg(REG_TOGGLE, toggle);
      write_reg(REG_FINISH, finish);
      write_reg(REG_TOTAL, total);
   endtask

   // well-formed flush run with random content, sometimes broken by a stray poll
   task automatic add_flush_run(input logic [31:0] step_max);
      logic [31:0] t;
      int          len;
      t = $urandom();
      case ($urandom_range(0, 3))
         0: add_poll(1'b1, 1'b0, t - 1);
         1: add_poll(1'b0, 1'b0, t - 1);
         default: ;
      endcase
      len = $urandom_range(4, 60);
      repeat (len) begin
         add_poll(1'b0, 1'b1, t);
         if ($urandom_range(0, 49) == 0)
            add_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
         if ($urandom_range(0, 39) == 0)
            t = t - $urandom_range(1, 100);
         else
            t = t + $urandom_range(0, step_max);
      end
   endtask

   initial begin
      logic [31:0] s;
      logic [31:0] step_max;
      int          phase_goal;
      timing    = '{PRIME_MS_RST, TOGGLE_MS_RST, FINISH_MS_RST, TOTAL_MS_RST};
      flush_seq = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset timing: off, run, both high, full flush cycle across a time wrap
      s = 32'hFFFF_FFF0;
      add_poll(1'b0, 1'b0, 32'h0000_0000);
      add_poll(1'b1, 1'b0, 32'hFFFF_FFFF);
      add_poll(1'b1, 1'b1, 32'h0000_3039);
      add_poll(1'b0, 1'b1, s);
      add_poll(1'b0, 1'b1, s + 32'd120000);
      add_poll(1'b0, 1'b1, s + 32'd130000);
      add_poll(1'b0, 1'b1, s + 32'd150000);
      add_poll(1'b0, 1'b1, s + 32'd190000);
      add_poll(1'b0, 1'b1, s + 32'd250000);
      add_poll(1'b0, 1'b1, s + 32'd10800000);
      add_poll(1'b1, 1'b0, 32'd5);
      add_poll(1'b0, 1'b1, 32'd1000);
      add_poll(1'b0, 1'b1, 32'd999);
      add_poll(1'b0, 1'b1, 32'd2000);
      wait_idle();

      // short timing: prime, alternation, finish hold and final off
      set_timing(32'd10, 32'd5, 32'd8, 32'd40);
      for (int t = 0; t <= 66; t += 6)
         add_poll(1'b0, 1'b1, t);
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin
               set_timing('0, '0, '0, '0);
               step_max = 20;
            end
            1: begin
               set_timing('1, '1, '1, '1);
               step_max = 32'hFFFF_FFFF;
            end
            2: begin
               set_timing($urandom_range(0, 40), '0, '1, '1);
               step_max = 15;
            end
            9: begin
               set_timing(PRIME_MS_RST, TOGGLE_MS_RST, FINISH_MS_RST, TOTAL_MS_RST);
               step_max = 200000;
            end
            default: begin
               set_timing(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 60),
                          $urandom_range(0, 30), $urandom_range(0, 60),
                          ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 400));
               step_max = $urandom_range(1, 30);
            end
         endcase
         phase_goal = polls_queued + 105;
         while (polls_queued < phase_goal) begin
            if ($urandom_range(0, 4) == 0)
               add_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
            else
               add_flush_run(step_max);
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && relay_expect_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
